[src/rrs_pkg.sv]
package rrs_pkg;

  localparam int ID_W       = 4;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 32;
  localparam int QUANTUM_W  = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [CFG_AW-1:0]    REG_QUANTUM_ADDR = 3'd0;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RST      = 8'd2;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ARRIVAL = 1'b1;

  // One classified event as it travels from the front to the back.
  typedef struct packed {
    logic               arrival;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] work;
    logic               bad;
  } item_t;

  typedef struct packed {
    logic               running_valid;
    logic [ID_W-1:0]    running_id;
    logic               finished;
    logic [TIME_W-1:0]  finish_time;
    logic               rejected;
  } res_t;

endpackage

[src/round_robin_time_slice_scheduler.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_tvalid/in_tready  tuser: opcode; tdata: task_id, burst_length
// out_      output     out_tvalid/out_tready tuser: flags; tdata: running_id, finish_time
// cfg_      APB slave  psel/penable/pready  quantum at byte address 0
//
// In the back-end sequencer an arrival passes through ARRIVE, and a tick through
// SWITCH, then POP and LOAD if a task is dispatched, RUN, and WORK if one runs; the
// task-queue and work-memory reads are registered. A two-entry queue decouples
// input from the sequencer, and the result register holds one finished
// transaction; the next item waits in the queue until that register is free.
// Reset is synchronous; the task-queue and work memories need no clearing.
module round_robin_time_slice_scheduler
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int WORK_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] task_id, [19:4] burst_length
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] running_id, [35:4] finish_time
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] running_valid, [1] finished, [2] rejected
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [QUANTUM_W-1:0] quantum_r;
  item_t                cls_item;
  item_t                q_item;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;
  logic                 in_fire;
  res_t                 res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_QUANTUM_ADDR) ?
                      CFG_DW'(quantum_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == REG_QUANTUM_ADDR)) begin
      quantum_r <= cfg_pwdata[QUANTUM_W-1:0];
    end
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  rrs_classify #(
    .MAX_TASKS (MAX_TASKS),
    .WORK_BITS (WORK_BITS)
  ) u_classify (
    .opcode       (in_tuser),
    .task_id      (in_tdata[ID_W-1:0]),
    .burst_length (in_tdata[ID_W+BURST_W-1:ID_W]),
    .item         (cls_item)
  );

  rrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_item)
  );

  rrs_exec #(
    .MAX_TASKS (MAX_TASKS),
    .WORK_BITS (WORK_BITS)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .quantum    (quantum_r),
    .item_valid (q_not_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'b0000, res.finish_time, res.running_id};
  assign out_tuser = {res.rejected, res.finished, res.running_valid};

endmodule

[src/rrs_classify.sv]
module rrs_classify
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int WORK_BITS = 16
) (
  input  logic               opcode,
  input  logic [ID_W-1:0]    task_id,
  input  logic [BURST_W-1:0] burst_length,
  output item_t              item
);

  localparam logic [BURST_W-1:0] WORK_MAX16 =
    (WORK_BITS >= BURST_W) ? {BURST_W{1'b1}} : BURST_W'((1 << WORK_BITS) - 1);

  logic id_range_bad;

  assign id_range_bad = (32'(task_id) >= MAX_TASKS);

  always_comb begin
    item.arrival = (opcode == OP_ARRIVAL);
    item.id      = task_id;
    // Bursts that do not fit the work counter saturate.
    item.work    = (burst_length > WORK_MAX16) ? WORK_MAX16 : burst_length;
    item.bad     = (burst_length == '0) || id_range_bad;
  end

endmodule

[src/rrs_queue.sv]
module rrs_queue
  import rrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/rrs_exec.sv]
module rrs_exec
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int WORK_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [QUANTUM_W-1:0] quantum,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 item_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_SWITCH,
    S_POP,
    S_LOAD,
    S_RUN,
    S_WORK
  } state_t;

  state_t                 state_r;
  item_t                  item_r;
  logic [IDX_W-1:0]       head_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [MAX_TASKS-1:0]   active_r;
  logic [IDX_W-1:0]       cur_r;
  logic                   cur_valid_r;
  logic [QUANTUM_W-1:0]   slice_r;
  logic [TIME_W-1:0]      time_r;
  logic                   out_valid_r;
  res_t                   res_r;

  logic [IDX_W-1:0]       fifo_mem [MAX_TASKS];
  logic [WORK_BITS-1:0]   work_mem [MAX_TASKS];
  logic [IDX_W-1:0]       fifo_q_r;
  logic [WORK_BITS-1:0]   work_q_r;

  logic [IDX_W-1:0]       aid;
  logic                   arrive_ok;
  logic                   do_switch;
  logic [CNT_W:0]         tail_sum;
  logic [IDX_W-1:0]       tail;
  logic [IDX_W-1:0]       head_nxt;
  logic [WORK_BITS-1:0]   work_nxt;
  logic                   fifo_we;
  logic [IDX_W-1:0]       fifo_wdata;
  logic                   work_we;
  logic [IDX_W-1:0]       work_waddr;
  logic [WORK_BITS-1:0]   work_wdata;
  logic                   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign item_pop  = (state_r == S_IDLE) && item_valid && out_free;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign aid       = IDX_W'(item_r.id);
  assign arrive_ok = !(item_r.bad || active_r[aid] || (cnt_r >= CNT_MAX));
  assign do_switch = !cur_valid_r || (slice_r >= quantum);

  // Tail pointer is head plus count, wrapped at the queue depth.
  assign tail_sum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(cnt_r);
  assign tail     = (tail_sum >= (CNT_W + 1)'(MAX_TASKS)) ?
                    IDX_W'(tail_sum - (CNT_W + 1)'(MAX_TASKS)) : IDX_W'(tail_sum);
  assign head_nxt = (head_r == IDX_W'(MAX_TASKS - 1)) ? '0 : head_r + IDX_W'(1);
  assign work_nxt = (work_q_r != '0) ? work_q_r - WORK_BITS'(1) : '0;

  always_comb begin
    fifo_we    = ((state_r == S_ARRIVE) && arrive_ok) ||
                 ((state_r == S_SWITCH) && do_switch && cur_valid_r);
    fifo_wdata = (state_r == S_ARRIVE) ? aid : cur_r;
    work_we    = ((state_r == S_ARRIVE) && arrive_ok) || (state_r == S_WORK);
    work_waddr = (state_r == S_ARRIVE) ? aid : cur_r;
    work_wdata = (state_r == S_ARRIVE) ? WORK_BITS'(item_r.work) : work_nxt;
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail] <= fifo_wdata;
    end
    if (state_r == S_POP) begin
      fifo_q_r <= fifo_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if (state_r == S_RUN) begin
      work_q_r <= work_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      active_r    <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      slice_r     <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (item_pop) begin
            item_r  <= item;
            state_r <= item.arrival ? S_ARRIVE : S_SWITCH;
          end
        end
        S_ARRIVE: begin
          if (arrive_ok) begin
            active_r[aid] <= 1'b1;
            cnt_r         <= cnt_r + CNT_W'(1);
          end
          res_r.running_valid <= 1'b0;
          res_r.running_id    <= '0;
          res_r.finished      <= 1'b0;
          res_r.finish_time   <= time_r;
          res_r.rejected      <= !arrive_ok;
          out_valid_r         <= 1'b1;
          state_r             <= S_IDLE;
        end
        S_SWITCH: begin
          if (do_switch) begin
            // A preempted task goes behind everything already queued.
            if (cur_valid_r) begin
              cnt_r       <= cnt_r + CNT_W'(1);
              cur_valid_r <= 1'b0;
            end
            state_r <= (cur_valid_r || (cnt_r != '0)) ? S_POP : S_RUN;
          end else begin
            state_r <= S_RUN;
          end
        end
        S_POP: begin
          head_r  <= head_nxt;
          cnt_r   <= cnt_r - CNT_W'(1);
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          cur_r       <= fifo_q_r;
          cur_valid_r <= 1'b1;
          slice_r     <= '0;
          state_r     <= S_RUN;
        end
        S_RUN: begin
          time_r <= time_r + TIME_W'(1);
          if (cur_valid_r) begin
            state_r <= S_WORK;
          end else begin
            res_r.running_valid <= 1'b0;
            res_r.running_id    <= '0;
            res_r.finished      <= 1'b0;
            res_r.finish_time   <= time_r + TIME_W'(1);
            res_r.rejected      <= 1'b0;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        S_WORK: begin
          res_r.running_valid <= 1'b1;
          res_r.running_id    <= ID_W'(cur_r);
          res_r.finished      <= (work_nxt == '0);
          res_r.finish_time   <= time_r;
          res_r.rejected      <= 1'b0;
          out_valid_r         <= 1'b1;
          if (work_nxt == '0) begin
            active_r[cur_r] <= 1'b0;
            cur_valid_r     <= 1'b0;
            slice_r         <= '0;
          end else begin
            slice_r <= slice_r + QUANTUM_W'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/rrs_checker.sv]
module rrs_checker
  import rrs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // A result waiting on the output stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only a task that ran can finish.
  a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("finished without a running task");

  // A refused arrival never reports a running task.
  a_rej_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && !out_tuser[1])
    else $error("rejected result shows a running task");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind round_robin_time_slice_scheduler rrs_checker u_rrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
